FILE: design/lut_interp_activation_top_assert.svh
// Assertion helpers shared by the activation block.
`ifndef LUT_INTERP_ACTIVATION_TOP_ASSERT_SVH
`define LUT_INTERP_ACTIVATION_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define LIA_ASSERT_HOLD(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Trigger in one cycle implies consequence in the next.
`define LIA_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lia_pkg.sv
package lia_pkg;

  localparam int TABLE_ENTRIES_DEF = 257;
  localparam int QUEUE_DEPTH       = 4;
  localparam int IDX_PORT_W        = 9;
  // sample offset is scaled by 16 before the index/fraction split
  localparam int SCALE_SHIFT       = 4;

  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] Q_ZERO    = 32'h0000_0000;

  localparam logic signed [31:0] DOMAIN_LOW_RST  = -32'sd524288;
  localparam logic signed [31:0] DOMAIN_HIGH_RST = 32'sd524288;

  typedef enum logic [1:0] {
    MODE_IDENTITY = 2'd0,
    MODE_RELU     = 2'd1,
    MODE_SIGMOID  = 2'd2,
    MODE_TANH     = 2'd3
  } lia_mode_e;

  typedef enum logic [1:0] {
    CFG_ACT_MODE    = 2'd0,
    CFG_DOMAIN_LOW  = 2'd1,
    CFG_DOMAIN_HIGH = 2'd2
  } lia_cfg_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } lia_cmd_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_INTERP = 2'd2
  } lia_kind_e;

  // One classified transaction as it travels from front to back.
  // data: table word for writes, final result for direct items.
  typedef struct packed {
    lia_kind_e   kind;
    logic [31:0] data;
    logic [15:0] frac;
  } lia_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lia_qstat_t;

endpackage

FILE: design/lia_ram.sv
module lia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: design/lia_fifo.sv
`include "lut_interp_activation_top_assert.svh"

module lia_fifo #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  rdata_o,
  output lia_pkg::lia_qstat_t stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

  `LIA_ASSERT_HOLD(a_fifo_count_bound, count_q <= CNT_W'(DEPTH), "queue count past depth")
  `LIA_ASSERT_NEXT(a_fifo_push_fills, do_push && !do_pop, !stat_o.empty, "queue lost a push")

endmodule

FILE: design/lia_front.sv
`include "lut_interp_activation_top_assert.svh"

module lia_front #(
  parameter int TABLE_ENTRIES = lia_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [31:0]                     cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            cmd_i,
  input  logic [lia_pkg::IDX_PORT_W-1:0]  entry_index_i,
  input  logic signed [31:0]              entry_value_i,
  input  logic signed [31:0]              sample_i,
  // toward the queue
  output logic                            push_o,
  output lia_pkg::lia_entry_t             entry_o,
  output logic [$clog2(TABLE_ENTRIES)-1:0] addr_o,
  input  lia_pkg::lia_qstat_t             qstat_i
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int RAW_W = 16 + lia_pkg::SCALE_SHIFT;
  localparam int FRH   = 15 - lia_pkg::SCALE_SHIFT;

  lia_pkg::lia_mode_e act_mode_q;
  logic signed [31:0] domain_low_q;
  logic signed [31:0] domain_high_q;

  lia_pkg::lia_entry_t entry_q, entry_d;
  logic [IDX_W-1:0]    addr_q, addr_d;
  logic                valid_q, valid_d;

  logic               take;
  logic               keep;
  logic               below, above;
  logic signed [32:0] shifted;
  logic [RAW_W-1:0]   raw_idx;
  logic [RAW_W-1:0]   clamped_idx;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mode_q    <= lia_pkg::MODE_IDENTITY;
      domain_low_q  <= lia_pkg::DOMAIN_LOW_RST;
      domain_high_q <= lia_pkg::DOMAIN_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lia_pkg::CFG_ACT_MODE:    act_mode_q    <= lia_pkg::lia_mode_e'(cfg_wdata_i[1:0]);
        lia_pkg::CFG_DOMAIN_LOW:  domain_low_q  <= cfg_wdata_i;
        lia_pkg::CFG_DOMAIN_HIGH: domain_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = valid_q && qstat_i.full;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = valid_q && !qstat_i.full;

  // offset from the low limit; inside the domain it lies in 1 .. 2^32-1
  assign below   = (sample_i <= domain_low_q);
  assign above   = (sample_i >= domain_high_q);
  assign shifted = {sample_i[31], sample_i} - {domain_low_q[31], domain_low_q};
  assign raw_idx = shifted[31:16-lia_pkg::SCALE_SHIFT];
  assign clamped_idx = (raw_idx >= RAW_W'(TABLE_ENTRIES - 1)) ?
                       RAW_W'(TABLE_ENTRIES - 2) : raw_idx;

  always_comb begin
    entry_d.kind = lia_pkg::KIND_DIRECT;
    entry_d.data = sample_i;
    entry_d.frac = {shifted[FRH:0], lia_pkg::SCALE_SHIFT'(0)};
    addr_d       = IDX_W'(clamped_idx);
    keep         = 1'b1;
    if (cmd_i == lia_pkg::CMD_WRITE) begin
      entry_d.kind = lia_pkg::KIND_WRITE;
      entry_d.data = entry_value_i;
      addr_d       = IDX_W'(entry_index_i);
      // writes past the table are dropped here
      keep         = (32'(entry_index_i) < 32'(TABLE_ENTRIES));
    end else begin
      unique case (act_mode_q)
        lia_pkg::MODE_IDENTITY: entry_d.data = sample_i;
        lia_pkg::MODE_RELU:     entry_d.data = (sample_i > 0) ? sample_i : lia_pkg::Q_ZERO;
        lia_pkg::MODE_SIGMOID, lia_pkg::MODE_TANH: begin
          if (below) begin
            entry_d.data = (act_mode_q == lia_pkg::MODE_TANH) ?
                           lia_pkg::Q_NEG_ONE : lia_pkg::Q_ZERO;
          end else if (above) begin
            entry_d.data = lia_pkg::Q_ONE;
          end else begin
            entry_d.kind = lia_pkg::KIND_INTERP;
          end
        end
        default: entry_d.data = sample_i;
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = keep;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      entry_q <= entry_d;
      addr_q  <= addr_d;
    end
  end

  assign entry_o = entry_q;
  assign addr_o  = addr_q;

  `LIA_ASSERT_NEXT(a_front_eval_kept, take && cmd_i == lia_pkg::CMD_EVAL, valid_q, "eval dropped")

endmodule

FILE: design/lia_back.sv
`include "lut_interp_activation_top_assert.svh"

module lia_back #(
  parameter int TABLE_ENTRIES = lia_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // from the queue
  output logic                             pop_o,
  input  lia_pkg::lia_entry_t              entry_i,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] addr_i,
  input  lia_pkg::lia_qstat_t              qstat_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [31:0]               activated_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  logic adv;

  logic                s1_valid_q;
  lia_pkg::lia_entry_t s1_entry_q;
  logic [31:0]         y0_rd, y1_rd;
  logic [IDX_W-1:0]    raddr_b;
  logic                ram_we;

  logic                s2_valid_q;
  lia_pkg::lia_kind_e  s2_kind_q;
  logic [31:0]         s2_data_q;
  logic [15:0]         s2_frac_q;
  logic [31:0]         s2_y0_q;
  logic signed [32:0]  s2_diff_q, s2_diff_d;

  logic                s3_valid_q;
  lia_pkg::lia_kind_e  s3_kind_q;
  logic [31:0]         s3_data_q;
  logic [31:0]         s3_y0_q;
  logic [31:0]         s3_interp_q;
  logic signed [49:0]  prod;

  logic                out_valid_q;
  logic [31:0]         out_data_q, out_data_d;

  // whole pipe moves unless the output register is held
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && !qstat_i.empty;

  assign ram_we  = pop_o && (entry_i.kind == lia_pkg::KIND_WRITE);
  assign raddr_b = (entry_i.kind == lia_pkg::KIND_INTERP) ? IDX_W'(addr_i + 1'b1) : addr_i;

  lia_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (addr_i),
    .wdata_i   (entry_i.data),
    .re_i      (adv),
    .raddr_a_i (addr_i),
    .raddr_b_i (raddr_b),
    .rdata_a_o (y0_rd),
    .rdata_b_o (y1_rd)
  );

  assign s2_diff_d  = {y1_rd[31], y1_rd} - {y0_rd[31], y0_rd};
  // signed diff times unsigned fraction; bits [47:16] are the floored term mod 2^32
  assign prod       = s2_diff_q * $signed({1'b0, s2_frac_q});
  assign out_data_d = (s3_kind_q == lia_pkg::KIND_INTERP) ? (s3_y0_q + s3_interp_q) : s3_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q && (s1_entry_q.kind != lia_pkg::KIND_WRITE);
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_entry_q  <= entry_i;
      s2_kind_q   <= s1_entry_q.kind;
      s2_data_q   <= s1_entry_q.data;
      s2_frac_q   <= s1_entry_q.frac;
      s2_y0_q     <= y0_rd;
      s2_diff_q   <= s2_diff_d;
      s3_kind_q   <= s2_kind_q;
      s3_data_q   <= s2_data_q;
      s3_y0_q     <= s2_y0_q;
      s3_interp_q <= prod[47:16];
      out_data_q  <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign activated_o = out_data_q;

  `LIA_ASSERT_NEXT(a_back_write_silent,
    adv && s1_valid_q && s1_entry_q.kind == lia_pkg::KIND_WRITE, !s2_valid_q,
    "table write produced a result")
  `LIA_ASSERT_NEXT(a_back_result_lands, adv && s3_valid_q, out_valid_q, "result lost")

endmodule

FILE: design/lut_interp_activation_top.sv
// Channel   | valid        | stall        | payload
// ----------+--------------+--------------+------------------------------------------
// input     | in_valid_i   | in_stall_o   | cmd_i, entry_index_i, entry_value_i, sample_i
// output    | out_valid_o  | out_stall_i  | activated_o
// config    | cfg_we_i     | (none)       | cfg_index_i, cfg_wdata_i
//
// One transaction per cycle sustained while nothing stalls; an evaluate result passes the
// input register (loaded at acceptance), then the queue, table read, difference,
// multiply and output register. Table writes produce no result.
// The back pipeline advances as a whole while the output register is empty or taken.
// The 4-deep queue absorbs output stalls; in_stall_o rises only when it is full.
// Reset (rst_ni, async low) empties all stages; the curve table is not cleared.
module lut_interp_activation_top #(
  parameter int TABLE_ENTRIES = lia_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [lia_pkg::IDX_PORT_W-1:0] entry_index_i,
  input  logic signed [31:0]             entry_value_i,
  input  logic signed [31:0]             sample_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             activated_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int Q_W   = IDX_W + $bits(lia_pkg::lia_entry_t);

  // front -> queue
  logic                push;
  lia_pkg::lia_entry_t front_entry;
  logic [IDX_W-1:0]    front_addr;
  lia_pkg::lia_qstat_t qstat;

  // queue -> back
  logic                pop;
  logic [Q_W-1:0]      q_head;
  lia_pkg::lia_entry_t back_entry;
  logic [IDX_W-1:0]    back_addr;

  // Front: config registers, domain test, index/fraction split.
  lia_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .sample_i      (sample_i),
    .push_o        (push),
    .entry_o       (front_entry),
    .addr_o        (front_addr),
    .qstat_i       (qstat)
  );

  // Short decoupling queue; carries table writes and evaluations in order.
  lia_fifo #(
    .WIDTH (Q_W),
    .DEPTH (lia_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_addr, front_entry}),
    .pop_i   (pop),
    .rdata_o (q_head),
    .stat_o  (qstat)
  );

  assign back_addr  = q_head[Q_W-1 -: IDX_W];
  assign back_entry = lia_pkg::lia_entry_t'(q_head[$bits(lia_pkg::lia_entry_t)-1:0]);

  // Back: table write/read, interpolation, output register.
  lia_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .entry_i     (back_entry),
    .addr_i      (back_addr),
    .qstat_i     (qstat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .activated_o (activated_o)
  );

endmodule
